>>> hw/rtl/rmis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_pkg
// Shared constants, opcodes, instruction word layout and the control and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package rmis_pkg;

  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 10;
  localparam int OP_W            = 5;
  localparam int REG_IDX_W       = 3;
  localparam int NUM_REGISTERS   = 8;
  localparam int DEF_INSTR_DEPTH = 1024;
  localparam int DEF_DATA_DEPTH  = 1024;

  localparam logic [REG_IDX_W-1:0] PC_INDEX = REG_IDX_W'(NUM_REGISTERS - 1);

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_STEP = 2'd1;
  localparam logic [1:0] CMD_READ = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_HALT     = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;
  localparam logic [1:0] ST_DIV_ZERO = 2'd3;

  localparam logic [OP_W-1:0] OP_HALT = 5'd0;
  localparam logic [OP_W-1:0] OP_IN   = 5'd1;
  localparam logic [OP_W-1:0] OP_OUT  = 5'd2;
  localparam logic [OP_W-1:0] OP_ADD  = 5'd3;
  localparam logic [OP_W-1:0] OP_SUB  = 5'd4;
  localparam logic [OP_W-1:0] OP_MUL  = 5'd5;
  localparam logic [OP_W-1:0] OP_DIV  = 5'd6;
  localparam logic [OP_W-1:0] OP_LD   = 5'd7;
  localparam logic [OP_W-1:0] OP_ST   = 5'd8;
  localparam logic [OP_W-1:0] OP_LDA  = 5'd9;
  localparam logic [OP_W-1:0] OP_LDC  = 5'd10;
  localparam logic [OP_W-1:0] OP_JLT  = 5'd11;
  localparam logic [OP_W-1:0] OP_JLE  = 5'd12;
  localparam logic [OP_W-1:0] OP_JGT  = 5'd13;
  localparam logic [OP_W-1:0] OP_JGE  = 5'd14;
  localparam logic [OP_W-1:0] OP_JEQ  = 5'd15;
  localparam logic [OP_W-1:0] OP_JNE  = 5'd16;

  typedef struct packed {
    logic [OP_W-1:0]      op;
    logic [REG_IDX_W-1:0] ra;
    logic [DATA_W-1:0]    b;
    logic [REG_IDX_W-1:0] rc;
  } instr_t;

  typedef struct packed {
    logic clear;
    logic accept;
    logic fetch;
    logic rd_t;
    logic rd_s;
    logic rd_r;
    logic exec;
    logic read_done;
    logic div_wb;
    logic ld_wb;
    logic emit;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic pc_ok;
    logic read_ok;
    logic exec_div;
    logic exec_load;
    logic div_done;
    logic out_free;
  } ctl_sts_t;

endpackage

>>> hw/rtl/rmis_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/rmis_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_div
// Signed 32-bit divider, truncating toward zero. Restoring shift-subtract on
// magnitudes, one quotient bit per cycle; done pulses once the last bit is in.
// ----------------------------------------------------------------------------
module rmis_div
  import rmis_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output logic              done,
  output logic [DATA_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DATA_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic              neg;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvsr;
  logic [DATA_W:0]   rem_shift;
  logic [DATA_W:0]   diff;

  assign rem_shift = {rem, quo[DATA_W-1]};
  assign diff      = rem_shift - {1'b0, dvsr};
  assign quotient  = neg ? (-quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(DATA_W - 1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg  <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      rem  <= '0;
      quo  <= dividend[DATA_W-1] ? (-dividend) : dividend;
      dvsr <= divisor[DATA_W-1] ? (-divisor) : divisor;
    end else if (busy) begin
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= rem_shift[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

endmodule

>>> hw/rtl/rmis_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_dp
// Datapath: register file, program counter, instruction and data RAMs,
// operand latches, ALU, divider, result staging and output register.
// ----------------------------------------------------------------------------
module rmis_dp
  import rmis_pkg::*;
#(
  parameter int INSTR_DEPTH = DEF_INSTR_DEPTH,
  parameter int DATA_DEPTH  = DEF_DATA_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctl_cmd_t                    cmd,
  output ctl_sts_t                    sts,
  input  logic [1:0]                  command,
  input  logic [ADDR_W-1:0]           address,
  input  logic [OP_W-1:0]             op_code,
  input  logic [REG_IDX_W-1:0]        reg_a,
  input  logic signed [DATA_W-1:0]    operand_b,
  input  logic [REG_IDX_W-1:0]        reg_c,
  input  logic signed [DATA_W-1:0]    in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  status,
  output logic                        value_valid,
  output logic signed [DATA_W-1:0]    value,
  output logic signed [DATA_W-1:0]    pc
);

  localparam int IAW       = $clog2(INSTR_DEPTH);
  localparam int DAW       = $clog2(DATA_DEPTH);
  localparam int MAX_DEPTH = (INSTR_DEPTH > DATA_DEPTH) ? INSTR_DEPTH : DATA_DEPTH;
  localparam int CW        = $clog2(MAX_DEPTH);

  logic [CW-1:0]          clr_cnt;
  logic [DATA_W-1:0]      clr_ext;
  logic [DATA_W-1:0]      addr_ext;
  logic [DATA_W-1:0]      prog_cnt;
  logic [DATA_W-1:0]      rf [0:NUM_REGISTERS-2];
  instr_t                 ir;
  logic [DATA_W-1:0]      in_val;
  logic [DATA_W-1:0]      treg;
  logic [DATA_W-1:0]      sreg;
  logic [DATA_W-1:0]      xreg;
  logic [DATA_W-1:0]      m;
  logic                   m_ok;
  logic                   load_ok;
  logic [REG_IDX_W-1:0]   rd_idx;
  logic [DATA_W-1:0]      rd_data;
  logic [DATA_W-1:0]      prod;
  logic                   x_neg;
  logic                   x_zero;

  logic                   wr_en;
  logic [REG_IDX_W-1:0]   wr_idx;
  logic [DATA_W-1:0]      wr_data;
  logic [1:0]             ex_status;
  logic                   ex_vvalid;
  logic                   div_start;
  logic                   div_done;
  logic [DATA_W-1:0]      div_q;

  logic                   imem_we;
  logic [IAW-1:0]         imem_waddr;
  instr_t                 imem_wdata;
  instr_t                 imem_q;
  logic                   dmem_we;
  logic [DAW-1:0]         dmem_waddr;
  logic [DATA_W-1:0]      dmem_wdata;
  logic [DAW-1:0]         dmem_raddr;
  logic [DATA_W-1:0]      dmem_q;

  logic [1:0]             res_status;
  logic                   res_vvalid;
  logic [DATA_W-1:0]      res_value;

  assign clr_ext  = DATA_W'(clr_cnt);
  assign addr_ext = {{(DATA_W-ADDR_W){1'b0}}, address};
  assign load_ok  = addr_ext < DATA_W'(INSTR_DEPTH);
  assign m        = ir.b + treg;
  assign m_ok     = !m[DATA_W-1] && (m < DATA_W'(DATA_DEPTH));
  assign prod     = sreg * treg;
  assign x_neg    = xreg[DATA_W-1];
  assign x_zero   = (xreg == '0);

  // status toward the controller
  assign sts.clear_done = (clr_cnt == CW'(MAX_DEPTH - 1));
  assign sts.pc_ok      = !prog_cnt[DATA_W-1] && (prog_cnt < DATA_W'(INSTR_DEPTH));
  assign sts.read_ok    = addr_ext < DATA_W'(DATA_DEPTH);
  assign sts.exec_div   = (ir.op == OP_DIV) && (treg != '0);
  assign sts.exec_load  = (ir.op == OP_LD) && m_ok;
  assign sts.div_done   = div_done;
  assign sts.out_free   = !out_valid || out_ready;

  // instruction store
  assign imem_we    = cmd.clear ? (clr_ext < DATA_W'(INSTR_DEPTH))
                                : (cmd.accept && (command == CMD_LOAD) && load_ok);
  assign imem_waddr = cmd.clear ? clr_ext[IAW-1:0] : addr_ext[IAW-1:0];
  assign imem_wdata = cmd.clear ? '0 : {op_code, reg_a, operand_b, reg_c};

  rmis_ram #(
    .WIDTH ($bits(instr_t)),
    .DEPTH (INSTR_DEPTH)
  ) u_imem (
    .clk   (clk),
    .we    (imem_we),
    .waddr (imem_waddr),
    .wdata (imem_wdata),
    .raddr (prog_cnt[IAW-1:0]),
    .rdata (imem_q)
  );

  // data store
  assign dmem_we    = cmd.clear ? (clr_ext < DATA_W'(DATA_DEPTH))
                                : (cmd.exec && (ir.op == OP_ST) && m_ok);
  assign dmem_waddr = cmd.clear ? clr_ext[DAW-1:0] : m[DAW-1:0];
  assign dmem_wdata = cmd.clear ? ((clr_cnt == '0) ? DATA_W'(DATA_DEPTH - 1) : '0) : xreg;
  assign dmem_raddr = cmd.accept ? addr_ext[DAW-1:0] : m[DAW-1:0];

  rmis_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DATA_DEPTH)
  ) u_dmem (
    .clk   (clk),
    .we    (dmem_we),
    .waddr (dmem_waddr),
    .wdata (dmem_wdata),
    .raddr (dmem_raddr),
    .rdata (dmem_q)
  );

  rmis_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sreg),
    .divisor  (treg),
    .done     (div_done),
    .quotient (div_q)
  );

  // register read port
  always_comb begin
    priority if (cmd.rd_t) begin
      rd_idx = ir.rc;
    end else if (cmd.rd_s) begin
      rd_idx = ir.b[REG_IDX_W-1:0];
    end else begin
      rd_idx = ir.ra;
    end
  end

  assign rd_data = (rd_idx == PC_INDEX) ? prog_cnt : rf[rd_idx];

  // execute and write-back
  always_comb begin
    wr_en     = 1'b0;
    wr_idx    = ir.ra;
    wr_data   = '0;
    ex_status = ST_OK;
    ex_vvalid = 1'b0;
    div_start = 1'b0;
    if (cmd.exec) begin
      unique case (ir.op)
        OP_HALT: ex_status = ST_HALT;
        OP_IN: begin
          wr_en   = 1'b1;
          wr_data = in_val;
        end
        OP_OUT: ex_vvalid = 1'b1;
        OP_ADD: begin
          wr_en   = 1'b1;
          wr_data = sreg + treg;
        end
        OP_SUB: begin
          wr_en   = 1'b1;
          wr_data = sreg - treg;
        end
        OP_MUL: begin
          wr_en   = 1'b1;
          wr_data = prod;
        end
        OP_DIV: begin
          if (treg == '0) begin
            ex_status = ST_DIV_ZERO;
          end else begin
            div_start = 1'b1;
          end
        end
        OP_LD, OP_ST: begin
          if (!m_ok) begin
            ex_status = ST_BAD_ADDR;
          end
        end
        OP_LDA: begin
          wr_en   = 1'b1;
          wr_data = m;
        end
        OP_LDC: begin
          wr_en   = 1'b1;
          wr_data = ir.b;
        end
        OP_JLT, OP_JLE, OP_JGT, OP_JGE, OP_JEQ, OP_JNE: begin
          wr_idx  = PC_INDEX;
          wr_data = m;
          unique case (ir.op)
            OP_JLT:  wr_en = x_neg;
            OP_JLE:  wr_en = x_neg || x_zero;
            OP_JGT:  wr_en = !x_neg && !x_zero;
            OP_JGE:  wr_en = !x_neg;
            OP_JEQ:  wr_en = x_zero;
            default: wr_en = !x_zero;
          endcase
        end
        default: ;
      endcase
    end else if (cmd.div_wb) begin
      wr_en   = 1'b1;
      wr_data = div_q;
    end else if (cmd.ld_wb) begin
      wr_en   = 1'b1;
      wr_data = dmem_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prog_cnt <= '0;
      for (int i = 0; i < NUM_REGISTERS - 1; i++) begin
        rf[i] <= '0;
      end
    end else begin
      if (cmd.fetch) begin
        prog_cnt <= prog_cnt + 1'b1;
      end else if (wr_en && (wr_idx == PC_INDEX)) begin
        prog_cnt <= wr_data;
      end
      if (wr_en && (wr_idx != PC_INDEX)) begin
        rf[wr_idx] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear && !sts.clear_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // operand latches
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_val <= in_value;
    end
    if (cmd.fetch) begin
      ir <= imem_q;
    end
    if (cmd.rd_t) begin
      treg <= rd_data;
    end
    if (cmd.rd_s) begin
      sreg <= rd_data;
    end
    if (cmd.rd_r) begin
      xreg <= rd_data;
    end
  end

  // result staging
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      res_vvalid <= 1'b0;
      res_value  <= '0;
      if ((command == CMD_STEP) && !sts.pc_ok) begin
        res_status <= ST_HALT;
      end else if ((command == CMD_READ) && !sts.read_ok) begin
        res_status <= ST_BAD_ADDR;
      end else begin
        res_status <= ST_OK;
      end
    end else if (cmd.read_done) begin
      res_vvalid <= 1'b1;
      res_value  <= dmem_q;
    end else if (cmd.exec) begin
      res_status <= ex_status;
      res_vvalid <= ex_vvalid;
      res_value  <= ex_vvalid ? xreg : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= res_status;
      value_valid <= res_vvalid;
      value       <= res_value;
      pc          <= prog_cnt;
    end
  end

  a_emit_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("result emitted over a pending transaction");

  a_fetch_increments_pc: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |=> (prog_cnt == $past(prog_cnt) + 1'b1))
    else $error("program counter not incremented on fetch");

  a_bad_pc_holds: assert property (@(posedge clk) disable iff (rst)
    (cmd.accept && (command == CMD_STEP) && !sts.pc_ok) |=> $stable(prog_cnt))
    else $error("program counter moved on a bad instruction address");

  a_div_wb_done: assert property (@(posedge clk) disable iff (rst)
    cmd.div_wb |-> div_done)
    else $error("quotient written back before divider finished");

  a_no_imem_write_in_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.fetch || cmd.exec) |-> !imem_we)
    else $error("instruction store written during a step");

endmodule

>>> hw/rtl/rmis_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmis_ctrl
// Controller: sequences store clearing, transaction decode, fetch, operand
// reads, execute, divide and load write-back, and result hand-off.
// ----------------------------------------------------------------------------
module rmis_ctrl
  import rmis_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] command,
  input  ctl_sts_t   sts,
  output ctl_cmd_t   cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_READ  = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_RDT   = 4'd4;
  localparam logic [3:0] S_RDS   = 4'd5;
  localparam logic [3:0] S_RDR   = 4'd6;
  localparam logic [3:0] S_EXEC  = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_LDWB  = 4'd9;
  localparam logic [3:0] S_RESP  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_done) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if ((command == CMD_STEP) && sts.pc_ok) begin
            state_next = S_FETCH;
          end else if ((command == CMD_READ) && sts.read_ok) begin
            state_next = S_READ;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_READ: begin
        cmd.read_done = 1'b1;
        state_next    = S_RESP;
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_RDT;
      end
      S_RDT: begin
        cmd.rd_t   = 1'b1;
        state_next = S_RDS;
      end
      S_RDS: begin
        cmd.rd_s   = 1'b1;
        state_next = S_RDR;
      end
      S_RDR: begin
        cmd.rd_r   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.exec_div) begin
          state_next = S_DIV;
        end else if (sts.exec_load) begin
          state_next = S_LDWB;
        end else begin
          state_next = S_RESP;
        end
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_wb = 1'b1;
          state_next = S_RESP;
        end
      end
      S_LDWB: begin
        cmd.ld_wb  = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hw/rtl/register_machine_instruction_step.sv
`timescale 1ns / 1ps
// Path, accept to result valid: load, unknown or refused commands go straight
// to the result hand-off, a read passes the read state, and a step passes
// fetch, operand reads and execute (ld adds load write-back, div the divider
// at one quotient bit per cycle). One transaction at a time; in_ready returns
// once the result is registered. Reset: registers cleared at once, then both
// stores are swept one word per cycle to the larger depth with in_ready low.
// ----------------------------------------------------------------------------
// register_machine_instruction_step
// Tiny machine interpreter: load instruction words, execute single steps,
// read data words. Multicycle controller plus datapath.
// ----------------------------------------------------------------------------
module register_machine_instruction_step
  import rmis_pkg::*;
#(
  parameter int INSTR_DEPTH = DEF_INSTR_DEPTH,
  parameter int DATA_DEPTH  = DEF_DATA_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [1:0]               command,
  input  logic [ADDR_W-1:0]        address,
  input  logic [OP_W-1:0]          op_code,
  input  logic [REG_IDX_W-1:0]     reg_a,
  input  logic signed [DATA_W-1:0] operand_b,
  input  logic [REG_IDX_W-1:0]     reg_c,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [1:0]               status,
  output logic                     value_valid,
  output logic signed [DATA_W-1:0] value,
  output logic signed [DATA_W-1:0] pc
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  rmis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .command  (command),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmis_dp #(
    .INSTR_DEPTH (INSTR_DEPTH),
    .DATA_DEPTH  (DATA_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .command     (command),
    .address     (address),
    .op_code     (op_code),
    .reg_a       (reg_a),
    .operand_b   (operand_b),
    .reg_c       (reg_c),
    .in_value    (in_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .value_valid (value_valid),
    .value       (value),
    .pc          (pc)
  );

endmodule
